/* rtl/core/ball_pair_elastic_collision_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent check macros used by the collision unit RTL.
// ---------------------------------------------------------------------------
`ifndef BALL_PAIR_ELASTIC_COLLISION_UNIT_ASSERT_SVH
`define BALL_PAIR_ELASTIC_COLLISION_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BPEC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BPEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BPEC_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define BPEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/core/bpec_pkg.sv */
// ---------------------------------------------------------------------------
// bpec_pkg
// Widths and item layouts of the ball pair collision unit.
// ---------------------------------------------------------------------------
package bpec_pkg;

  localparam int POS_W       = 21;
  localparam int VEL_W       = 16;
  localparam int RADIUS_W    = 16;
  localparam int SPD_W       = 17;
  localparam int SQ_RAD_W    = 34;
  localparam int SQ_ROOT_W   = SQ_RAD_W / 2;
  localparam int IN_TDATA_W  = 184;
  localparam int OUT_TDATA_W = 168;

  typedef struct packed {
    logic [RADIUS_W-1:0] b_radius;
    logic [VEL_W-1:0]    b_vel_y;
    logic [VEL_W-1:0]    b_vel_x;
    logic [POS_W-1:0]    b_pos_y;
    logic [POS_W-1:0]    b_pos_x;
    logic [RADIUS_W-1:0] a_radius;
    logic [VEL_W-1:0]    a_vel_y;
    logic [VEL_W-1:0]    a_vel_x;
    logic [POS_W-1:0]    a_pos_y;
    logic [POS_W-1:0]    a_pos_x;
  } in_item_t;

  typedef struct packed {
    logic [SPD_W-1:0] rel_speed;
    logic [VEL_W-1:0] new_b_vel_y;
    logic [VEL_W-1:0] new_b_vel_x;
    logic [POS_W-1:0] new_b_pos_y;
    logic [POS_W-1:0] new_b_pos_x;
    logic [VEL_W-1:0] new_a_vel_y;
    logic [VEL_W-1:0] new_a_vel_x;
    logic [POS_W-1:0] new_a_pos_y;
    logic [POS_W-1:0] new_a_pos_x;
  } res_t;

endpackage

/* rtl/core/bpec_delay.sv */
// ---------------------------------------------------------------------------
// bpec_delay
// Enabled shift line that carries side data alongside the pipeline.
// ---------------------------------------------------------------------------
module bpec_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[DEPTH-1];

endmodule

/* rtl/core/bpec_div_pipe.sv */
// ---------------------------------------------------------------------------
// bpec_div_pipe
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module bpec_div_pipe #(
  parameter int DEN_W = 34,
  parameter int QUO_W = 18
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [DEN_W+QUO_W-1:0] num,
  input  logic [DEN_W-1:0]       den,
  output logic [QUO_W-1:0]       quo
);

  localparam int NUM_W = DEN_W + QUO_W;

  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] lo_q  [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];

  logic [DEN_W-1:0] rem_in [QUO_W];
  logic [QUO_W-1:0] lo_in  [QUO_W];
  logic [QUO_W-1:0] quo_in [QUO_W];
  logic [DEN_W-1:0] den_in [QUO_W];
  logic [DEN_W:0]   cur    [QUO_W];
  logic [DEN_W:0]   diff   [QUO_W];
  logic             ge     [QUO_W];
  logic [DEN_W-1:0] rem_next [QUO_W];
  logic [QUO_W-1:0] lo_next  [QUO_W];
  logic [QUO_W-1:0] quo_next [QUO_W];

  always_comb begin
    rem_in[0] = num[NUM_W-1:QUO_W];
    lo_in[0]  = num[QUO_W-1:0];
    quo_in[0] = '0;
    den_in[0] = den;
    for (int i = 1; i < QUO_W; i++) begin
      rem_in[i] = rem_q[i-1];
      lo_in[i]  = lo_q[i-1];
      quo_in[i] = quo_q[i-1];
      den_in[i] = den_q[i-1];
    end
    for (int i = 0; i < QUO_W; i++) begin
      cur[i]      = {rem_in[i], lo_in[i][QUO_W-1]};
      diff[i]     = cur[i] - {1'b0, den_in[i]};
      ge[i]       = cur[i] >= {1'b0, den_in[i]};
      rem_next[i] = ge[i] ? diff[i][DEN_W-1:0] : cur[i][DEN_W-1:0];
      lo_next[i]  = {lo_in[i][QUO_W-2:0], 1'b0};
      quo_next[i] = {quo_in[i][QUO_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QUO_W; i++) begin
        rem_q[i] <= rem_next[i];
        lo_q[i]  <= lo_next[i];
        quo_q[i] <= quo_next[i];
        den_q[i] <= den_in[i];
      end
    end
  end

  assign quo = quo_q[QUO_W-1];

endmodule

/* rtl/core/bpec_isqrt_pipe.sv */
// ---------------------------------------------------------------------------
// bpec_isqrt_pipe
// Pipelined integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
module bpec_isqrt_pipe (
  input  logic                          clk,
  input  logic                          en,
  input  logic [bpec_pkg::SQ_RAD_W-1:0] rad,
  output logic [bpec_pkg::SQ_ROOT_W-1:0] root
);

  import bpec_pkg::*;

  logic [SQ_ROOT_W+1:0] rem_q [SQ_ROOT_W];
  logic [SQ_ROOT_W-1:0] rt_q  [SQ_ROOT_W];
  logic [SQ_RAD_W-1:0]  rd_q  [SQ_ROOT_W];

  logic [SQ_ROOT_W+1:0] rem_in   [SQ_ROOT_W];
  logic [SQ_ROOT_W-1:0] rt_in    [SQ_ROOT_W];
  logic [SQ_RAD_W-1:0]  rd_in    [SQ_ROOT_W];
  logic [SQ_ROOT_W+1:0] cur      [SQ_ROOT_W];
  logic [SQ_ROOT_W+1:0] trial    [SQ_ROOT_W];
  logic                 ge       [SQ_ROOT_W];
  logic [SQ_ROOT_W+1:0] rem_next [SQ_ROOT_W];
  logic [SQ_ROOT_W-1:0] rt_next  [SQ_ROOT_W];
  logic [SQ_RAD_W-1:0]  rd_next  [SQ_ROOT_W];

  always_comb begin
    rem_in[0] = '0;
    rt_in[0]  = '0;
    rd_in[0]  = rad;
    for (int i = 1; i < SQ_ROOT_W; i++) begin
      rem_in[i] = rem_q[i-1];
      rt_in[i]  = rt_q[i-1];
      rd_in[i]  = rd_q[i-1];
    end
    for (int i = 0; i < SQ_ROOT_W; i++) begin
      cur[i]      = {rem_in[i][SQ_ROOT_W-1:0], rd_in[i][SQ_RAD_W-1 -: 2]};
      trial[i]    = {rt_in[i], 2'b01};
      ge[i]       = cur[i] >= trial[i];
      rem_next[i] = ge[i] ? cur[i] - trial[i] : cur[i];
      rt_next[i]  = {rt_in[i][SQ_ROOT_W-2:0], ge[i]};
      rd_next[i]  = {rd_in[i][SQ_RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SQ_ROOT_W; i++) begin
        rem_q[i] <= rem_next[i];
        rt_q[i]  <= rt_next[i];
        rd_q[i]  <= rd_next[i];
      end
    end
  end

  assign root = rt_q[SQ_ROOT_W-1];

endmodule

/* rtl/core/ball_pair_elastic_collision_unit.sv */
// ---------------------------------------------------------------------------
// ball_pair_elastic_collision_unit
// Equal-mass elastic collision of one circle pair, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   The slave channel takes one circle pair per transaction (s_tdata), the
//   master channel returns one result per transaction: the resolved flag on
//   m_tuser and the new centers, velocities and relative speed on m_tdata.
//   Every input gives exactly one result, in order.
//   Throughput is one pair per cycle while the output is not stalled; the
//   depth comes from the 17-stage square roots, the 18-stage velocity
//   divider and the 17-stage push divider, each of which retires one bit
//   per stage.
//   A synchronous rst empties the pipeline and the output buffer.
//   When the receiver stalls, the result waits in the output register and
//   one more result leaving the pipeline is still taken into a skid register;
//   after that the whole pipeline holds and s_tready drops until the skid drains.
// ---------------------------------------------------------------------------
`include "ball_pair_elastic_collision_unit_assert.svh"

module ball_pair_elastic_collision_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius,
  // b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, zero pad
  input  logic [bpec_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y, new_b_pos_x,
  // new_b_pos_y, new_b_vel_x, new_b_vel_y, rel_speed, zero pad
  output logic [bpec_pkg::OUT_TDATA_W-1:0] m_tdata,
  // hit
  output logic [0:0]                       m_tuser
);

  import bpec_pkg::*;

  localparam int NSTG = 41;

  typedef struct packed {
    logic hit;
    logic qxn;
    logic qyn;
    logic dxn;
    logic dyn;
  } flags_t;

  function automatic logic [VEL_W-1:0] sat_vel(input logic signed [19:0] v);
    if (v > 20'sd32767) begin
      return 16'h7fff;
    end else if (v < -20'sd32768) begin
      return 16'h8000;
    end
    return v[VEL_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [21:0] v);
    if (v > 22'sd1048575) begin
      return 21'h0fffff;
    end else if (v < -22'sd1048576) begin
      return 21'h100000;
    end
    return v[POS_W-1:0];
  endfunction

  logic            adv;
  logic [NSTG-1:0] vld;
  in_item_t        in_item;

  assign in_item = in_item_t'(s_tdata[$bits(in_item_t)-1:0]);

  // stage 1
  in_item_t           s1_item;
  logic signed [21:0] s1_dx, s1_dy;
  logic signed [16:0] s1_rvx, s1_rvy;
  logic [16:0]        s1_rsum;
  // stage 2
  logic signed [43:0] s2_dxx, s2_dyy;
  logic signed [38:0] s2_kx, s2_ky;
  logic signed [33:0] s2_rxx, s2_ryy;
  logic [33:0]        s2_rr;
  logic signed [21:0] s2_dx, s2_dy;
  // stage 3
  logic [43:0]        s3_d2;
  logic signed [39:0] s3_k;
  logic [33:0]        s3_rv2, s3_r2;
  logic signed [21:0] s3_dx, s3_dy;
  // stage 4
  flags_t             s4_fl;
  logic [16:0]        s4_adx, s4_ady;
  logic [34:0]        s4_ak;
  logic [33:0]        s4_d2;
  logic [21:0]        adx_c, ady_c;
  logic [39:0]        ak_c;
  // stage 5
  logic [34:0]        s5_p0x, s5_p0y;
  logic [33:0]        s5_p1x, s5_p1y;
  logic [33:0]        s5_d2;
  // stage 6
  logic [51:0]        s6_numx, s6_numy;
  logic [33:0]        s6_d2;
  // stage 20 to 23
  logic [16:0]        s20_dist, s20_spd, s20_rsum, s20_adx, s20_ady;
  logic [16:0]        s21_ov, s21_adx, s21_ady;
  logic [17:0]        s21_den, s22_den, s23_den;
  logic [33:0]        s22_px, s22_py;
  logic [34:0]        s23_numx, s23_numy;
  // stage 24 and 40
  logic [17:0]        s24_qx, s24_qy, s40_qx, s40_qy;
  logic [16:0]        s40_sx, s40_sy, s40_spd;
  flags_t             s40_fl;
  in_item_t           s40_item;
  // final stage
  logic signed [18:0] qx_s, qy_s;
  logic signed [17:0] sx_s, sy_s;
  logic signed [19:0] navx_w, navy_w, nbvx_w, nbvy_w;
  logic signed [21:0] nax_w, nay_w, nbx_w, nby_w;
  res_t               res_c;
  logic               s41_hit;
  res_t               s41_res;
  // output buffer
  logic               out_v, skid_v;
  logic               out_hit, skid_hit;
  res_t               out_res, skid_res;

  assign adv      = !skid_v;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], s_tvalid};
    end
  end

  always_comb begin
    adx_c = s3_dx[21] ? 22'(-s3_dx) : s3_dx;
    ady_c = s3_dy[21] ? 22'(-s3_dy) : s3_dy;
    ak_c  = s3_k[39]  ? 40'(-s3_k)  : s3_k;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item <= in_item;
      s1_dx   <= $signed({in_item.a_pos_x[POS_W-1], in_item.a_pos_x})
               - $signed({in_item.b_pos_x[POS_W-1], in_item.b_pos_x});
      s1_dy   <= $signed({in_item.a_pos_y[POS_W-1], in_item.a_pos_y})
               - $signed({in_item.b_pos_y[POS_W-1], in_item.b_pos_y});
      s1_rvx  <= $signed({in_item.a_vel_x[VEL_W-1], in_item.a_vel_x})
               - $signed({in_item.b_vel_x[VEL_W-1], in_item.b_vel_x});
      s1_rvy  <= $signed({in_item.a_vel_y[VEL_W-1], in_item.a_vel_y})
               - $signed({in_item.b_vel_y[VEL_W-1], in_item.b_vel_y});
      s1_rsum <= {1'b0, in_item.a_radius} + {1'b0, in_item.b_radius};

      s2_dxx <= s1_dx * s1_dx;
      s2_dyy <= s1_dy * s1_dy;
      s2_kx  <= s1_rvx * s1_dx;
      s2_ky  <= s1_rvy * s1_dy;
      s2_rxx <= s1_rvx * s1_rvx;
      s2_ryy <= s1_rvy * s1_rvy;
      s2_rr  <= s1_rsum * s1_rsum;
      s2_dx  <= s1_dx;
      s2_dy  <= s1_dy;

      s3_d2  <= s2_dxx[43:0] + s2_dyy[43:0];
      s3_k   <= $signed({s2_kx[38], s2_kx}) + $signed({s2_ky[38], s2_ky});
      s3_rv2 <= {1'b0, s2_rxx[32:0]} + {1'b0, s2_ryy[32:0]};
      s3_r2  <= s2_rr;
      s3_dx  <= s2_dx;
      s3_dy  <= s2_dy;

      s4_fl.hit <= (s3_d2 != '0) && (s3_d2 < {10'b0, s3_r2}) && s3_k[39];
      s4_fl.qxn <= s3_dx[21] ^ s3_k[39];
      s4_fl.qyn <= s3_dy[21] ^ s3_k[39];
      s4_fl.dxn <= s3_dx[21];
      s4_fl.dyn <= s3_dy[21];
      s4_adx    <= adx_c[16:0];
      s4_ady    <= ady_c[16:0];
      s4_ak     <= ak_c[34:0];
      s4_d2     <= s3_d2[33:0];

      s5_p0x <= s4_adx * s4_ak[17:0];
      s5_p1x <= s4_adx * s4_ak[34:18];
      s5_p0y <= s4_ady * s4_ak[17:0];
      s5_p1y <= s4_ady * s4_ak[34:18];
      s5_d2  <= s4_d2;

      s6_numx <= {s5_p1x, 18'b0} + {17'b0, s5_p0x} + {19'b0, s5_d2[33:1]};
      s6_numy <= {s5_p1y, 18'b0} + {17'b0, s5_p0y} + {19'b0, s5_d2[33:1]};
      s6_d2   <= s5_d2;

      s21_ov  <= s20_rsum - s20_dist;
      s21_den <= {s20_dist, 1'b0};
      s21_adx <= s20_adx;
      s21_ady <= s20_ady;

      s22_px  <= s21_adx * s21_ov;
      s22_py  <= s21_ady * s21_ov;
      s22_den <= s21_den;

      s23_numx <= {1'b0, s22_px} + {18'b0, s22_den[17:1]};
      s23_numy <= {1'b0, s22_py} + {18'b0, s22_den[17:1]};
      s23_den  <= s22_den;

      s41_hit <= s40_fl.hit;
      s41_res <= res_c;
    end
  end

  bpec_isqrt_pipe u_dist (.clk(clk), .en(adv), .rad(s3_d2[33:0]), .root(s20_dist));
  bpec_isqrt_pipe u_spd  (.clk(clk), .en(adv), .rad(s3_rv2),      .root(s20_spd));

  bpec_div_pipe #(.DEN_W(34), .QUO_W(18)) u_qx (
    .clk(clk), .en(adv), .num(s6_numx), .den(s6_d2), .quo(s24_qx)
  );
  bpec_div_pipe #(.DEN_W(34), .QUO_W(18)) u_qy (
    .clk(clk), .en(adv), .num(s6_numy), .den(s6_d2), .quo(s24_qy)
  );
  bpec_div_pipe #(.DEN_W(18), .QUO_W(17)) u_sx (
    .clk(clk), .en(adv), .num(s23_numx), .den(s23_den), .quo(s40_sx)
  );
  bpec_div_pipe #(.DEN_W(18), .QUO_W(17)) u_sy (
    .clk(clk), .en(adv), .num(s23_numy), .den(s23_den), .quo(s40_sy)
  );

  bpec_delay #(.WIDTH($bits(in_item_t)), .DEPTH(39)) u_d_item (
    .clk(clk), .en(adv), .d(s1_item), .q(s40_item)
  );
  bpec_delay #(.WIDTH(17), .DEPTH(19)) u_d_rsum (
    .clk(clk), .en(adv), .d(s1_rsum), .q(s20_rsum)
  );
  bpec_delay #(.WIDTH(34), .DEPTH(16)) u_d_abs (
    .clk(clk), .en(adv), .d({s4_adx, s4_ady}), .q({s20_adx, s20_ady})
  );
  bpec_delay #(.WIDTH($bits(flags_t)), .DEPTH(36)) u_d_flags (
    .clk(clk), .en(adv), .d(s4_fl), .q(s40_fl)
  );
  bpec_delay #(.WIDTH(36), .DEPTH(16)) u_d_q (
    .clk(clk), .en(adv), .d({s24_qx, s24_qy}), .q({s40_qx, s40_qy})
  );
  bpec_delay #(.WIDTH(17), .DEPTH(20)) u_d_spd (
    .clk(clk), .en(adv), .d(s20_spd), .q(s40_spd)
  );

  always_comb begin
    qx_s = s40_fl.qxn ? -$signed({1'b0, s40_qx}) : $signed({1'b0, s40_qx});
    qy_s = s40_fl.qyn ? -$signed({1'b0, s40_qy}) : $signed({1'b0, s40_qy});
    sx_s = s40_fl.dxn ? -$signed({1'b0, s40_sx}) : $signed({1'b0, s40_sx});
    sy_s = s40_fl.dyn ? -$signed({1'b0, s40_sy}) : $signed({1'b0, s40_sy});

    navx_w = $signed({{4{s40_item.a_vel_x[VEL_W-1]}}, s40_item.a_vel_x})
           - $signed({qx_s[18], qx_s});
    navy_w = $signed({{4{s40_item.a_vel_y[VEL_W-1]}}, s40_item.a_vel_y})
           - $signed({qy_s[18], qy_s});
    nbvx_w = $signed({{4{s40_item.b_vel_x[VEL_W-1]}}, s40_item.b_vel_x})
           + $signed({qx_s[18], qx_s});
    nbvy_w = $signed({{4{s40_item.b_vel_y[VEL_W-1]}}, s40_item.b_vel_y})
           + $signed({qy_s[18], qy_s});

    nax_w = $signed({s40_item.a_pos_x[POS_W-1], s40_item.a_pos_x})
          + $signed({{4{sx_s[17]}}, sx_s});
    nay_w = $signed({s40_item.a_pos_y[POS_W-1], s40_item.a_pos_y})
          + $signed({{4{sy_s[17]}}, sy_s});
    nbx_w = $signed({s40_item.b_pos_x[POS_W-1], s40_item.b_pos_x})
          - $signed({{4{sx_s[17]}}, sx_s});
    nby_w = $signed({s40_item.b_pos_y[POS_W-1], s40_item.b_pos_y})
          - $signed({{4{sy_s[17]}}, sy_s});

    if (s40_fl.hit) begin
      res_c.new_a_pos_x = sat_pos(nax_w);
      res_c.new_a_pos_y = sat_pos(nay_w);
      res_c.new_a_vel_x = sat_vel(navx_w);
      res_c.new_a_vel_y = sat_vel(navy_w);
      res_c.new_b_pos_x = sat_pos(nbx_w);
      res_c.new_b_pos_y = sat_pos(nby_w);
      res_c.new_b_vel_x = sat_vel(nbvx_w);
      res_c.new_b_vel_y = sat_vel(nbvy_w);
      res_c.rel_speed   = s40_spd;
    end else begin
      res_c.new_a_pos_x = s40_item.a_pos_x;
      res_c.new_a_pos_y = s40_item.a_pos_y;
      res_c.new_a_vel_x = s40_item.a_vel_x;
      res_c.new_a_vel_y = s40_item.a_vel_y;
      res_c.new_b_pos_x = s40_item.b_pos_x;
      res_c.new_b_pos_y = s40_item.b_pos_y;
      res_c.new_b_vel_x = s40_item.b_vel_x;
      res_c.new_b_vel_y = s40_item.b_vel_y;
      res_c.rel_speed   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || m_tready) begin
      if (skid_v) begin
        out_v    <= 1'b1;
        out_hit  <= skid_hit;
        out_res  <= skid_res;
        skid_v   <= 1'b0;
      end else begin
        out_v    <= vld[NSTG-1];
        out_hit  <= s41_hit;
        out_res  <= s41_res;
      end
    end else if (adv && vld[NSTG-1]) begin
      skid_v   <= 1'b1;
      skid_hit <= s41_hit;
      skid_res <= s41_res;
    end
  end

  assign m_tvalid = out_v;
  assign m_tuser  = out_hit;
  assign m_tdata  = {{(OUT_TDATA_W - $bits(res_t)){1'b0}}, out_res};

  `BPEC_ASSERT_NOW(a_skid_needs_out, clk, rst, skid_v, out_v, "skid full while output empty")
  `BPEC_ASSERT_NEXT(a_hold_on_stall, clk, rst, !adv, $stable(vld), "pipeline moved during stall")
  `BPEC_ASSERT_NOW(a_hit_has_speed, clk, rst, out_v && out_hit, out_res.rel_speed != '0,
                   "resolved pair with zero relative speed")
  `BPEC_ASSERT_NOW(a_miss_no_speed, clk, rst, out_v && !out_hit, out_res.rel_speed == '0,
                   "unresolved pair reports a speed")

endmodule
